### sv/psbc_pkg.sv
// Shared constants, register indexes and payload types of the seam blend and crop block.
// Used by every module and interface of the block; depends on nothing.

package psbc_pkg;

    // Canvas limits; columns and rows beyond them never reach the pipeline.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SPAN_W  = COL_W + 1;   // holds MAX_WIDTH, crop width and fade width
    localparam int LINES_W = ROW_W + 1;   // holds MAX_HEIGHT and crop height

    localparam int CFG_DATA_W = (SPAN_W > LINES_W) ? SPAN_W : LINES_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_END   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT = CFG_IDX_W'(5);

    localparam logic [COL_W-1:0]   RST_BLEND_START = COL_W'(400);
    localparam logic [COL_W-1:0]   RST_BLEND_END   = COL_W'(600);
    localparam logic [COL_W-1:0]   RST_CROP_LEFT   = COL_W'(30);
    localparam logic [ROW_W-1:0]   RST_CROP_TOP    = ROW_W'(10);
    localparam logic [SPAN_W-1:0]  RST_CROP_WIDTH  = SPAN_W'(1040);
    localparam logic [LINES_W-1:0] RST_CROP_HEIGHT = LINES_W'(460);

    localparam int PIX_W   = 8;
    localparam int ALPHA_W = PIX_W + 1;                    // alpha runs 0..256
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << PIX_W;
    localparam int Q_W     = ALPHA_W;                      // quotient runs 0..256
    localparam int NUM_W   = COL_W + ALPHA_W + 1;          // 512*i + w - 2
    localparam int DEN_W   = SPAN_W;                       // 2*(w - 1)
    localparam int PROD_W  = PIX_W + ALPHA_W;

    typedef struct packed {
        logic [COL_W-1:0]   blend_start;
        logic [COL_W-1:0]   blend_end;
        logic [COL_W-1:0]   crop_left;
        logic [ROW_W-1:0]   crop_top;
        logic [SPAN_W-1:0]  crop_width;
        logic [LINES_W-1:0] crop_height;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] c2;
        logic [PIX_W-1:0] c1;
        logic [PIX_W-1:0] c0;
    } rgb_t;

    // Pixel pair plus framing flags, carried unchanged down the pipeline
    typedef struct packed {
        rgb_t left;
        rgb_t right;
        logic row_end;
        logic frame_end;
    } lr_t;

    typedef struct packed {
        lr_t                px;
        logic               fixed;
        logic [ALPHA_W-1:0] alpha_fix;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        lr_t                px;
        logic               fixed;
        logic [ALPHA_W-1:0] alpha_fix;
        logic [Q_W-1:0]     quo;
    } quo_t;

endpackage

### sv/psbc_pixel_if.sv
// Input channel of the seam blend and crop block: canvas position and both camera pixels.
// Depends on psbc_pkg.

interface psbc_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [psbc_pkg::COL_W-1:0]  col;
    logic [psbc_pkg::ROW_W-1:0]  row;
    logic [psbc_pkg::PIX_W-1:0]  left_c0;
    logic [psbc_pkg::PIX_W-1:0]  left_c1;
    logic [psbc_pkg::PIX_W-1:0]  left_c2;
    logic [psbc_pkg::PIX_W-1:0]  right_c0;
    logic [psbc_pkg::PIX_W-1:0]  right_c1;
    logic [psbc_pkg::PIX_W-1:0]  right_c2;

    modport source (output valid, col, row, left_c0, left_c1, left_c2,
                    right_c0, right_c1, right_c2, input ready);
    modport sink   (input valid, col, row, left_c0, left_c1, left_c2,
                    right_c0, right_c1, right_c2, output ready);
endinterface

### sv/psbc_result_if.sv
// Output channel of the seam blend and crop block: composed pixel and framing flags.
// Depends on psbc_pkg.

interface psbc_result_if;
    logic                        valid;
    logic                        ready;
    logic [psbc_pkg::PIX_W-1:0]  out_c0;
    logic [psbc_pkg::PIX_W-1:0]  out_c1;
    logic [psbc_pkg::PIX_W-1:0]  out_c2;
    logic                        row_end;
    logic                        frame_end;

    modport source (output valid, out_c0, out_c1, out_c2, row_end, frame_end, input ready);
    modport sink   (input valid, out_c0, out_c1, out_c2, row_end, frame_end, output ready);
endinterface

### sv/panorama_seam_blend_crop_unit.sv
// Panorama seam blend and crop: one canvas pixel in, at most one composed pixel out.
// Depends on psbc_pkg, psbc_pixel_if, psbc_result_if, psbc_cfg, psbc_front,
// psbc_div and psbc_mix.
//
// pixel carries the canvas column and row with the remapped left and right
// camera pixels; result carries the blended pixel with row_end and frame_end.
// Both use valid/ready; a request moves when both are high. Pixels outside
// the crop window are taken and dropped without a result.
// The configuration port writes register wr_index with wr_data whenever wr_en
// is high; write only while no request is in flight.
// Throughput is one pixel per clock while result.ready stays high. A request
// passes two front end stages, nine divider stages (one quotient bit each)
// for the ramp, and two blend stages ending in the output register.
// When result.ready is low, each stage holds its request and the stages
// behind it keep filling any empty slots; pixel.ready falls only once every
// stage is full.
// Reset clears all valid bits and loads the register defaults; no clearing
// pass is needed.

module panorama_seam_blend_crop_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [psbc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [psbc_pkg::CFG_DATA_W-1:0]   wr_data,
    psbc_pixel_if.sink                        pixel,
    psbc_result_if.source                     result
);

    psbc_pkg::cfg_t      cfg;
    psbc_pkg::div_req_t  div_req;
    logic                div_req_valid;
    logic                div_req_ready;
    psbc_pkg::quo_t      div_rsp;
    logic                div_rsp_valid;
    logic                div_rsp_ready;

    psbc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    psbc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixel     (pixel),
        .req       (div_req),
        .req_valid (div_req_valid),
        .req_ready (div_req_ready)
    );

    psbc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .req_valid (div_req_valid),
        .req_ready (div_req_ready),
        .rsp       (div_rsp),
        .rsp_valid (div_rsp_valid),
        .rsp_ready (div_rsp_ready)
    );

    psbc_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rsp       (div_rsp),
        .rsp_valid (div_rsp_valid),
        .rsp_ready (div_rsp_ready),
        .result    (result)
    );

    a_out_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.frame_end |-> result.row_end)
        else $error("result frame end without row end");

endmodule

### sv/psbc_cfg.sv
// Configuration register bank of the seam blend and crop block.
// Depends on psbc_pkg.

module psbc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [psbc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [psbc_pkg::CFG_DATA_W-1:0]     wr_data,
    output psbc_pkg::cfg_t                      cfg
);

    psbc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_start <= psbc_pkg::RST_BLEND_START;
            cfg_reg.blend_end   <= psbc_pkg::RST_BLEND_END;
            cfg_reg.crop_left   <= psbc_pkg::RST_CROP_LEFT;
            cfg_reg.crop_top    <= psbc_pkg::RST_CROP_TOP;
            cfg_reg.crop_width  <= psbc_pkg::RST_CROP_WIDTH;
            cfg_reg.crop_height <= psbc_pkg::RST_CROP_HEIGHT;
        end
        else if (wr_en)
        begin
            // drop writes to indexes beyond the bank
            unique case (wr_index)
                psbc_pkg::REG_BLEND_START:
                    cfg_reg.blend_start <= wr_data[psbc_pkg::COL_W-1:0];
                psbc_pkg::REG_BLEND_END:
                    cfg_reg.blend_end   <= wr_data[psbc_pkg::COL_W-1:0];
                psbc_pkg::REG_CROP_LEFT:
                    cfg_reg.crop_left   <= wr_data[psbc_pkg::COL_W-1:0];
                psbc_pkg::REG_CROP_TOP:
                    cfg_reg.crop_top    <= wr_data[psbc_pkg::ROW_W-1:0];
                psbc_pkg::REG_CROP_WIDTH:
                    cfg_reg.crop_width  <= wr_data[psbc_pkg::SPAN_W-1:0];
                psbc_pkg::REG_CROP_HEIGHT:
                    cfg_reg.crop_height <= wr_data[psbc_pkg::LINES_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/psbc_front.sv
// Two-stage front end: crop window test, framing flags, fade zone classification,
// and set-up of the alpha division. Depends on psbc_pkg and psbc_pixel_if.

module psbc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  psbc_pkg::cfg_t      cfg,
    psbc_pixel_if.sink          pixel,
    output psbc_pkg::div_req_t  req,
    output logic                req_valid,
    input  logic                req_ready
);

    typedef struct packed {
        psbc_pkg::lr_t                   px;
        logic                            left_side;
        logic                            right_side;
        logic [psbc_pkg::SPAN_W-1:0]     w;
        logic [psbc_pkg::COL_W-1:0]      i;
    } cls_t;

    localparam int XS_W = psbc_pkg::SPAN_W + 1;
    localparam int YS_W = psbc_pkg::LINES_W + 1;

    logic [XS_W-1:0]                x_sum;
    logic [YS_W-1:0]                y_sum;
    logic [psbc_pkg::SPAN_W-1:0]    x_end;
    logic [psbc_pkg::LINES_W-1:0]   y_end;
    logic [psbc_pkg::SPAN_W-1:0]    col_x;
    logic [psbc_pkg::LINES_W-1:0]   row_x;
    logic [psbc_pkg::SPAN_W-1:0]    s_x;
    logic [psbc_pkg::SPAN_W-1:0]    e_x;
    logic                           in_window;
    logic                           last_col;
    logic                           last_row;
    cls_t                           cls_next;
    cls_t                           cls_reg;
    logic                           cls_valid_reg;
    logic                           cls_ready;
    psbc_pkg::div_req_t             req_next;
    psbc_pkg::div_req_t             req_reg;
    logic                           req_valid_reg;
    logic                           req_free;

    // Stage 1: window, flags and zone
    always_comb
    begin
        x_sum = XS_W'(cfg.crop_left) + XS_W'(cfg.crop_width);
        y_sum = YS_W'(cfg.crop_top) + YS_W'(cfg.crop_height);
        x_end = (x_sum > XS_W'(psbc_pkg::MAX_WIDTH)) ?
                psbc_pkg::SPAN_W'(psbc_pkg::MAX_WIDTH) : x_sum[psbc_pkg::SPAN_W-1:0];
        y_end = (y_sum > YS_W'(psbc_pkg::MAX_HEIGHT)) ?
                psbc_pkg::LINES_W'(psbc_pkg::MAX_HEIGHT) : y_sum[psbc_pkg::LINES_W-1:0];
        col_x = psbc_pkg::SPAN_W'(pixel.col);
        row_x = psbc_pkg::LINES_W'(pixel.row);

        in_window = (pixel.col >= cfg.crop_left) && (col_x < x_end) &&
                    (pixel.row >= cfg.crop_top) && (row_x < y_end);
        last_col = (col_x + psbc_pkg::SPAN_W'(1)) == x_end;
        last_row = (row_x + psbc_pkg::LINES_W'(1)) == y_end;

        // effective end is at least one past the start
        s_x = psbc_pkg::SPAN_W'(cfg.blend_start);
        e_x = (cfg.blend_end > cfg.blend_start) ? psbc_pkg::SPAN_W'(cfg.blend_end)
                                                : s_x + psbc_pkg::SPAN_W'(1);

        cls_next.px.left.c0   = pixel.left_c0;
        cls_next.px.left.c1   = pixel.left_c1;
        cls_next.px.left.c2   = pixel.left_c2;
        cls_next.px.right.c0  = pixel.right_c0;
        cls_next.px.right.c1  = pixel.right_c1;
        cls_next.px.right.c2  = pixel.right_c2;
        cls_next.px.row_end   = last_col;
        cls_next.px.frame_end = last_col && last_row;
        cls_next.left_side    = pixel.col < cfg.blend_start;
        cls_next.right_side   = col_x >= e_x;
        cls_next.w            = e_x - s_x;
        cls_next.i            = pixel.col - cfg.blend_start;
    end

    // Stage 2: fixed alpha or numerator and denominator of the ramp
    always_comb
    begin
        req_next.px        = cls_reg.px;
        req_next.fixed     = cls_reg.left_side || cls_reg.right_side ||
                             (cls_reg.w == psbc_pkg::SPAN_W'(1));
        req_next.alpha_fix = cls_reg.right_side ? '0 : psbc_pkg::ALPHA_ONE;
        req_next.num       = psbc_pkg::NUM_W'({cls_reg.i, {psbc_pkg::ALPHA_W{1'b0}}})
                             + psbc_pkg::NUM_W'(cls_reg.w) - psbc_pkg::NUM_W'(2);
        req_next.den       = psbc_pkg::DEN_W'({cls_reg.w - psbc_pkg::SPAN_W'(1), 1'b0});
    end

    assign req_free    = !req_valid_reg || req_ready;
    assign cls_ready   = !cls_valid_reg || req_free;
    assign pixel.ready = cls_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            // drop requests outside the crop window here
            if (cls_ready)
            begin
                cls_valid_reg <= pixel.valid && in_window;
            end
            if (req_free)
            begin
                req_valid_reg <= cls_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_ready && pixel.valid)
        begin
            cls_reg <= cls_next;
        end
        if (req_free && cls_valid_reg)
        begin
            req_reg <= req_next;
        end
    end

    assign req       = req_reg;
    assign req_valid = req_valid_reg;

    a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
        cls_valid_reg && cls_reg.px.frame_end |-> cls_reg.px.row_end)
        else $error("frame end flagged without row end");

endmodule

### sv/psbc_div.sv
// Pipelined restoring divider for the cross-fade ramp, one quotient bit per stage.
// Depends on psbc_pkg.

module psbc_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  psbc_pkg::div_req_t  req,
    input  logic                req_valid,
    output logic                req_ready,
    output psbc_pkg::quo_t      rsp,
    output logic                rsp_valid,
    input  logic                rsp_ready
);

    localparam int STAGES = psbc_pkg::Q_W;

    typedef struct packed {
        psbc_pkg::lr_t                   px;
        logic                            fixed;
        logic [psbc_pkg::ALPHA_W-1:0]    alpha_fix;
        logic [psbc_pkg::NUM_W-1:0]      rem;
        logic [psbc_pkg::DEN_W-1:0]      den;
        logic [psbc_pkg::Q_W-1:0]        quo;
    } div_st_t;

    div_st_t            st_src  [STAGES];
    div_st_t            st_next [STAGES];
    div_st_t            st_reg  [STAGES];
    logic [STAGES-1:0]  v_reg;
    logic [STAGES-1:0]  adv;
    logic [STAGES-1:0]  src_valid;

    // Stall each stage only while it holds a request that cannot move on
    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || rsp_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign req_ready = adv[0];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - k;
        logic [psbc_pkg::NUM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                st_src[k].px        = req.px;
                st_src[k].fixed     = req.fixed;
                st_src[k].alpha_fix = req.alpha_fix;
                st_src[k].rem       = req.num;
                st_src[k].den       = req.den;
                st_src[k].quo       = '0;
            end
            assign src_valid[k] = req_valid;
        end
        else
        begin : g_rest
            assign st_src[k]    = st_reg[k-1];
            assign src_valid[k] = v_reg[k-1];
        end

        always_comb
        begin
            trial      = psbc_pkg::NUM_W'(st_src[k].den) << BIT;
            st_next[k] = st_src[k];
            if (st_src[k].rem >= trial)
            begin
                st_next[k].rem      = st_src[k].rem - trial;
                st_next[k].quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_valid[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= src_valid[k];
                end
            end
        end
    end

    always_comb
    begin
        rsp.px        = st_reg[STAGES-1].px;
        rsp.fixed     = st_reg[STAGES-1].fixed;
        rsp.alpha_fix = st_reg[STAGES-1].alpha_fix;
        rsp.quo       = st_reg[STAGES-1].quo;
    end

    assign rsp_valid = v_reg[STAGES-1];

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && !st_reg[STAGES-1].fixed
        |-> st_reg[STAGES-1].quo <= psbc_pkg::ALPHA_ONE)
        else $error("ramp quotient above full scale");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && !st_reg[STAGES-1].fixed
        |-> st_reg[STAGES-1].rem < psbc_pkg::NUM_W'(st_reg[STAGES-1].den))
        else $error("division left a remainder not below the divisor");

endmodule

### sv/psbc_mix.sv
// Alpha blend of the three channels: weighted products, then sum and scale into
// the output register. Depends on psbc_pkg and psbc_result_if.

module psbc_mix
(
    input  logic                clk,
    input  logic                rst_n,
    input  psbc_pkg::quo_t      rsp,
    input  logic                rsp_valid,
    output logic                rsp_ready,
    psbc_result_if.source       result
);

    localparam int CH = 3;

    logic [psbc_pkg::PIX_W-1:0]    lv [CH];
    logic [psbc_pkg::PIX_W-1:0]    rv [CH];
    logic [psbc_pkg::ALPHA_W-1:0]  alpha;
    logic [psbc_pkg::ALPHA_W-1:0]  beta;
    logic [psbc_pkg::PROD_W-1:0]   lp_next [CH];
    logic [psbc_pkg::PROD_W-1:0]   rp_next [CH];
    logic [psbc_pkg::PROD_W-1:0]   lp_reg  [CH];
    logic [psbc_pkg::PROD_W-1:0]   rp_reg  [CH];
    logic [psbc_pkg::PROD_W-1:0]   sum     [CH];
    logic [psbc_pkg::ALPHA_W-1:0]  alpha_reg;
    logic                          row_end_reg;
    logic                          frame_end_reg;
    logic                          prod_valid_reg;
    logic                          prod_ready;
    logic [psbc_pkg::PIX_W-1:0]    out_reg [CH];
    logic                          out_row_end_reg;
    logic                          out_frame_end_reg;
    logic                          out_valid_reg;
    logic                          out_free;

    always_comb
    begin
        lv[0] = rsp.px.left.c0;
        lv[1] = rsp.px.left.c1;
        lv[2] = rsp.px.left.c2;
        rv[0] = rsp.px.right.c0;
        rv[1] = rsp.px.right.c1;
        rv[2] = rsp.px.right.c2;
        alpha = rsp.fixed ? rsp.alpha_fix : psbc_pkg::ALPHA_ONE - rsp.quo;
        beta  = psbc_pkg::ALPHA_ONE - alpha;
        for (int c = 0; c < CH; c++)
        begin
            lp_next[c] = psbc_pkg::PROD_W'(lv[c]) * psbc_pkg::PROD_W'(alpha);
            rp_next[c] = psbc_pkg::PROD_W'(rv[c]) * psbc_pkg::PROD_W'(beta);
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            sum[c] = lp_reg[c] + rp_reg[c];
        end
    end

    assign out_free   = !out_valid_reg || result.ready;
    assign prod_ready = !prod_valid_reg || out_free;
    assign rsp_ready  = prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= rsp_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && rsp_valid)
        begin
            lp_reg        <= lp_next;
            rp_reg        <= rp_next;
            alpha_reg     <= alpha;
            row_end_reg   <= rsp.px.row_end;
            frame_end_reg <= rsp.px.frame_end;
        end
        // hold the result while the receiver stalls
        if (out_free && prod_valid_reg)
        begin
            for (int c = 0; c < CH; c++)
            begin
                out_reg[c] <= sum[c][psbc_pkg::PIX_W +: psbc_pkg::PIX_W];
            end
            out_row_end_reg   <= row_end_reg;
            out_frame_end_reg <= frame_end_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_c0    = out_reg[0];
    assign result.out_c1    = out_reg[1];
    assign result.out_c2    = out_reg[2];
    assign result.row_end   = out_row_end_reg;
    assign result.frame_end = out_frame_end_reg;

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> alpha_reg <= psbc_pkg::ALPHA_ONE)
        else $error("blend weight above full scale");

endmodule

### bench/tb.sv
// Self-checking bench for panorama_seam_blend_crop_unit: a directed table, then random pixel
// streams under changing fade and crop settings, each result checked against its table row or a local predictor.
// Depends on psbc_pkg, psbc_pixel_if, psbc_result_if and the unit itself.

module tb;

    localparam int COL_W      = psbc_pkg::COL_W;
    localparam int ROW_W      = psbc_pkg::ROW_W;
    localparam int PIX_W      = psbc_pkg::PIX_W;
    localparam int SPAN_W     = psbc_pkg::SPAN_W;
    localparam int LINES_W    = psbc_pkg::LINES_W;
    localparam int CFG_IDX_W  = psbc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = psbc_pkg::CFG_DATA_W;
    localparam int MAX_WIDTH  = psbc_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = psbc_pkg::MAX_HEIGHT;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 8;
    localparam int PHASE_PIXELS = 135;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        psbc_pkg::rgb_t   left;
        psbc_pkg::rgb_t   right;
    } pixel_t;

    typedef struct packed {
        psbc_pkg::rgb_t pix;
        logic           row_end;
        logic           frame_end;
    } composed_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        pixel_t                px;
        bit                    known;
        bit                    emit;
        composed_t             res;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    psbc_pixel_if  pixel_bus();
    psbc_result_if result_bus();

    panorama_seam_blend_crop_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixel    (pixel_bus),
        .result   (result_bus)
    );

    psbc_pkg::cfg_t canvas_cfg;
    composed_t      composed_q[$];
    plan_row_t      plan[$];
    int             errors = 0;
    int             pixels_sent = 0;
    int             directed_sent = 0;
    int             composed_checked = 0;
    int             settings_applied = 0;
    bit             steady = 1'b0;
    int             hold_off = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_draw();
        if (steady)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [PIX_W-1:0] mix8(logic [PIX_W-1:0] l, logic [PIX_W-1:0] r,
                                              int unsigned alpha);
        int unsigned v;
        v = (l * alpha + r * (256 - alpha)) >> 8;
        return v[PIX_W-1:0];
    endfunction

    // Crop test, then the fade ramp, then the framing flags
    function automatic bit compose_pixel(input psbc_pkg::cfg_t c, input pixel_t p,
                                         output composed_t r);
        int unsigned x_end, y_end, s, e, w, i, alpha;
        r = '0;
        x_end = c.crop_left + c.crop_width;
        if (x_end > MAX_WIDTH)
            x_end = MAX_WIDTH;
        y_end = c.crop_top + c.crop_height;
        if (y_end > MAX_HEIGHT)
            y_end = MAX_HEIGHT;
        s = c.blend_start;
        e = (c.blend_end > c.blend_start) ? c.blend_end : s + 1;
        if (p.col < c.crop_left || p.col >= x_end || p.row < c.crop_top || p.row >= y_end)
            return 1'b0;
        if (p.col < s)
            alpha = 256;
        else if (p.col >= e)
            alpha = 0;
        else
        begin
            w = e - s;
            i = p.col - s;
            alpha = (w == 1) ? 256 : 256 - (512 * i + w - 2) / (2 * (w - 1));
        end
        r.pix.c0 = mix8(p.left.c0, p.right.c0, alpha);
        r.pix.c1 = mix8(p.left.c1, p.right.c1, alpha);
        r.pix.c2 = mix8(p.left.c2, p.right.c2, alpha);
        r.row_end = (p.col + 1 == x_end);
        r.frame_end = r.row_end && (p.row + 1 == y_end);
        return 1'b1;
    endfunction

    function automatic int skewed(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Fill the bits above the register's width with noise; the block must drop them
    function automatic logic [CFG_DATA_W-1:0] with_noise(int v, int w);
        logic [CFG_DATA_W-1:0] n;
        n = CFG_DATA_W'($urandom);
        n = (w >= CFG_DATA_W) ? '0 : (n >> w) << w;
        return n | CFG_DATA_W'(v);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int x_lo, x_hi, y_lo, y_hi, e, f_lo, f_hi;
        x_lo = canvas_cfg.crop_left;
        x_hi = canvas_cfg.crop_left + canvas_cfg.crop_width;
        x_hi = ((x_hi > MAX_WIDTH) ? MAX_WIDTH : x_hi) - 1;
        y_lo = canvas_cfg.crop_top;
        y_hi = canvas_cfg.crop_top + canvas_cfg.crop_height;
        y_hi = ((y_hi > MAX_HEIGHT) ? MAX_HEIGHT : y_hi) - 1;
        e = (canvas_cfg.blend_end > canvas_cfg.blend_start) ?
            canvas_cfg.blend_end : canvas_cfg.blend_start + 1;
        f_lo = (canvas_cfg.blend_start > x_lo) ? canvas_cfg.blend_start : x_lo;
        f_hi = (e - 1 < x_hi) ? e - 1 : x_hi;
        p.col = COL_W'($urandom);
        p.row = ROW_W'($urandom);
        if (x_hi >= x_lo && $urandom_range(0, 99) < 75)
        begin
            case ($urandom_range(0, 9))
                0: p.col = COL_W'(x_hi);
                1, 2, 3, 4: p.col = (f_hi >= f_lo) ? COL_W'($urandom_range(f_lo, f_hi)) :
                                                     COL_W'($urandom_range(x_lo, x_hi));
                default: p.col = COL_W'($urandom_range(x_lo, x_hi));
            endcase
        end
        if (y_hi >= y_lo && $urandom_range(0, 99) < 80)
            p.row = ($urandom_range(0, 6) == 0) ? ROW_W'(y_hi) : ROW_W'($urandom_range(y_lo, y_hi));
        p.left = 24'($urandom);
        p.right = 24'($urandom);
        if ($urandom_range(0, 9) == 0)
            p.left = '1;
        if ($urandom_range(0, 9) == 0)
            p.right = '0;
        return p;
    endfunction

    function automatic plan_row_t px_row(int col, int row, psbc_pkg::rgb_t l,
                                         psbc_pkg::rgb_t r);
        plan_row_t t;
        t = '{default: '0};
        t.px.col = COL_W'(col);
        t.px.row = ROW_W'(row);
        t.px.left = l;
        t.px.right = r;
        return t;
    endfunction

    function automatic plan_row_t px_known(int col, int row, psbc_pkg::rgb_t l,
                                           psbc_pkg::rgb_t r, bit emit, psbc_pkg::rgb_t o,
                                           bit re, bit fe);
        plan_row_t t;
        t = px_row(col, row, l, r);
        t.known = 1'b1;
        t.emit = emit;
        t.res.pix = o;
        t.res.row_end = re;
        t.res.frame_end = fe;
        return t;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int data);
        plan_row_t t;
        t = '{default: '0};
        t.is_write = 1'b1;
        t.idx = idx;
        t.data = CFG_DATA_W'(data);
        return t;
    endfunction

    // Append one row to the directed table
    function automatic void plan_add(plan_row_t t);
        plan.insert(plan.size(), t);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        case (idx)
            psbc_pkg::REG_BLEND_START: canvas_cfg.blend_start = data[COL_W-1:0];
            psbc_pkg::REG_BLEND_END:   canvas_cfg.blend_end   = data[COL_W-1:0];
            psbc_pkg::REG_CROP_LEFT:   canvas_cfg.crop_left   = data[COL_W-1:0];
            psbc_pkg::REG_CROP_TOP:    canvas_cfg.crop_top    = data[ROW_W-1:0];
            psbc_pkg::REG_CROP_WIDTH:  canvas_cfg.crop_width  = data[SPAN_W-1:0];
            psbc_pkg::REG_CROP_HEIGHT: canvas_cfg.crop_height = data[LINES_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait for every expected result, then let dropped pixels clear
    task automatic drain_block();
        pixel_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (composed_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(input pixel_t p, input bit known, input bit known_emit,
                              input composed_t known_res);
        int gap;
        bit emit;
        composed_t r;
        gap = idle_draw();
        if (gap > 0)
        begin
            pixel_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.col <= p.col;
        pixel_bus.row <= p.row;
        pixel_bus.left_c0 <= p.left.c0;
        pixel_bus.left_c1 <= p.left.c1;
        pixel_bus.left_c2 <= p.left.c2;
        pixel_bus.right_c0 <= p.right.c0;
        pixel_bus.right_c1 <= p.right.c1;
        pixel_bus.right_c2 <= p.right.c2;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        if (known)
        begin
            emit = known_emit;
            r = known_res;
        end
        else
            emit = compose_pixel(canvas_cfg, p, r);
        if (emit)
            composed_q.insert(composed_q.size(), r);
        pixels_sent++;
    endtask

    task automatic new_settings(input bit widest);
        int s, e, cl, ct, cw, ch;
        if (widest)
        begin
            s = 0;
            e = MAX_WIDTH - 1;
            cl = 0;
            ct = 0;
            cw = MAX_WIDTH;
            ch = MAX_HEIGHT;
        end
        else
        begin
            s = skewed(0, MAX_WIDTH - 1);
            e = $urandom_range(0, 1) ? skewed(0, MAX_WIDTH - 1) : s + $urandom_range(1, 300);
            if (e > MAX_WIDTH - 1)
                e = MAX_WIDTH - 1;
            cl = ($urandom_range(0, 2) == 0) ? skewed(0, MAX_WIDTH - 1) : $urandom_range(0, 400);
            ct = ($urandom_range(0, 2) == 0) ? skewed(0, MAX_HEIGHT - 1) : $urandom_range(0, 200);
            case ($urandom_range(0, 7))
                0: cw = 0;
                1: cw = 4095;
                2: cw = 10;
                default: cw = $urandom_range(10, MAX_WIDTH);
            endcase
            case ($urandom_range(0, 7))
                0: ch = 0;
                1: ch = 2047;
                2: ch = 10;
                default: ch = $urandom_range(10, MAX_HEIGHT);
            endcase
        end
        drain_block();
        write_reg(psbc_pkg::REG_BLEND_START, with_noise(s, COL_W));
        write_reg(psbc_pkg::REG_BLEND_END, with_noise(e, COL_W));
        write_reg(psbc_pkg::REG_CROP_LEFT, with_noise(cl, COL_W));
        write_reg(psbc_pkg::REG_CROP_TOP, with_noise(ct, ROW_W));
        write_reg(psbc_pkg::REG_CROP_WIDTH, with_noise(cw, SPAN_W));
        write_reg(psbc_pkg::REG_CROP_HEIGHT, with_noise(ch, LINES_W));
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
        wr_en <= 1'b0;
        settings_applied++;
    endtask

    // Result side: random stalls, one long hold-off on request, field-by-field check
    initial
    begin
        int stall;
        composed_t want;
        result_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = (hold_off > 0) ? hold_off : idle_draw();
            hold_off = 0;
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
            if (composed_q.size() == 0)
            begin
                $error("result with no pixel expected: c0 %0h c1 %0h c2 %0h",
                       result_bus.out_c0, result_bus.out_c1, result_bus.out_c2);
                errors++;
            end
            else
            begin
                want = composed_q.pop_front();
                composed_checked++;
                if (result_bus.out_c0 !== want.pix.c0)
                begin
                    $error("out_c0: expected %0h, got %0h", want.pix.c0, result_bus.out_c0);
                    errors++;
                end
                if (result_bus.out_c1 !== want.pix.c1)
                begin
                    $error("out_c1: expected %0h, got %0h", want.pix.c1, result_bus.out_c1);
                    errors++;
                end
                if (result_bus.out_c2 !== want.pix.c2)
                begin
                    $error("out_c2: expected %0h, got %0h", want.pix.c2, result_bus.out_c2);
                    errors++;
                end
                if (result_bus.row_end !== want.row_end)
                begin
                    $error("row_end: expected %0b, got %0b", want.row_end, result_bus.row_end);
                    errors++;
                end
                if (result_bus.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end,
                           result_bus.frame_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        bit last_write;
        last_write = 1'b0;
        rst_n <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= '0;
        wr_data <= '0;
        pixel_bus.valid <= 1'b0;
        pixel_bus.col <= '0;
        pixel_bus.row <= '0;
        pixel_bus.left_c0 <= '0;
        pixel_bus.left_c1 <= '0;
        pixel_bus.left_c2 <= '0;
        pixel_bus.right_c0 <= '0;
        pixel_bus.right_c1 <= '0;
        pixel_bus.right_c2 <= '0;
        canvas_cfg.blend_start = psbc_pkg::RST_BLEND_START;
        canvas_cfg.blend_end = psbc_pkg::RST_BLEND_END;
        canvas_cfg.crop_left = psbc_pkg::RST_CROP_LEFT;
        canvas_cfg.crop_top = psbc_pkg::RST_CROP_TOP;
        canvas_cfg.crop_width = psbc_pkg::RST_CROP_WIDTH;
        canvas_cfg.crop_height = psbc_pkg::RST_CROP_HEIGHT;

        // Reset settings: fade 400..599, crop columns 30..1069, rows 10..469
        plan_add(px_known(29, 10, 24'hFFFFFF, 24'h000000, 0, 24'h0, 0, 0));
        plan_add(px_known(30, 10, 24'hFFFFFF, 24'h000000, 1, 24'hFFFFFF, 0, 0));
        plan_add(px_known(400, 200, 24'h000000, 24'hFFFFFF, 1, 24'h000000, 0, 0));
        plan_add(px_known(599, 200, 24'hFFFFFF, 24'h000000, 1, 24'h000000, 0, 0));
        plan_add(px_known(600, 200, 24'hFFFFFF, 24'hA55AC3, 1, 24'hA55AC3, 0, 0));
        plan_add(px_row(500, 300, 24'h80FF01, 24'h7F00FE));
        plan_add(px_known(1069, 100, 24'h123456, 24'hABCDEF, 1, 24'hABCDEF, 1, 0));
        plan_add(px_known(1069, 469, 24'h123456, 24'hABCDEF, 1, 24'hABCDEF, 1, 1));
        plan_add(px_known(1070, 469, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 0, 0));
        plan_add(px_known(500, 9, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 0, 0));
        plan_add(px_known(500, 470, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 0, 0));
        plan_add(px_known(2047, 1023, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 0, 0));
        // Fade end below start, crop window far past the canvas
        plan_add(reg_row(psbc_pkg::REG_BLEND_START, 2046));
        plan_add(reg_row(psbc_pkg::REG_BLEND_END, 5));
        plan_add(reg_row(psbc_pkg::REG_CROP_LEFT, 0));
        plan_add(reg_row(psbc_pkg::REG_CROP_TOP, 12'hC00));
        plan_add(reg_row(psbc_pkg::REG_CROP_WIDTH, 4095));
        plan_add(reg_row(psbc_pkg::REG_CROP_HEIGHT, 2047));
        plan_add(px_known(0, 0, 24'hFFFFFF, 24'h000000, 1, 24'hFFFFFF, 0, 0));
        plan_add(px_known(2046, 5, 24'h3C5A96, 24'hC3A569, 1, 24'h3C5A96, 0, 0));
        plan_add(px_known(2047, 1023, 24'h000000, 24'hFFFFFF, 1, 24'hFFFFFF, 1, 1));
        plan_add(px_known(2047, 0, 24'h000000, 24'h5A5A5A, 1, 24'h5A5A5A, 1, 0));
        // Empty crop window, by width then by height
        plan_add(reg_row(psbc_pkg::REG_CROP_WIDTH, 0));
        plan_add(px_known(100, 100, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 0, 0));
        plan_add(reg_row(psbc_pkg::REG_CROP_WIDTH, 10));
        plan_add(reg_row(psbc_pkg::REG_CROP_HEIGHT, 0));
        plan_add(px_known(5, 5, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 0, 0));
        // One-pixel window in the far corner, widest fade
        plan_add(reg_row(psbc_pkg::REG_CROP_HEIGHT, 10));
        plan_add(reg_row(psbc_pkg::REG_BLEND_START, 0));
        plan_add(reg_row(psbc_pkg::REG_BLEND_END, 2047));
        plan_add(reg_row(psbc_pkg::REG_CROP_LEFT, 2047));
        plan_add(reg_row(psbc_pkg::REG_CROP_TOP, 1023));
        plan_add(px_known(2047, 1023, 24'h111111, 24'hEEEEEE, 1, 24'hEEEEEE, 1, 1));
        plan_add(px_known(2046, 1023, 24'h111111, 24'hEEEEEE, 0, 24'h0, 0, 0));
        // Two-column fade, full canvas; spare indexes must not disturb anything
        plan_add(reg_row(psbc_pkg::REG_BLEND_START, 100));
        plan_add(reg_row(psbc_pkg::REG_BLEND_END, 102));
        plan_add(reg_row(psbc_pkg::REG_CROP_LEFT, 0));
        plan_add(reg_row(psbc_pkg::REG_CROP_TOP, 0));
        plan_add(reg_row(psbc_pkg::REG_CROP_WIDTH, 2048));
        plan_add(reg_row(psbc_pkg::REG_CROP_HEIGHT, 1024));
        plan_add(reg_row(REG_SPARE_LO, 12'hFFF));
        plan_add(reg_row(REG_SPARE_HI, 12'hFFF));
        plan_add(px_row(100, 3, 24'hC8641E, 24'h1E64C8));
        plan_add(px_row(101, 3, 24'hC8641E, 24'h1E64C8));
        plan_add(px_known(50, 1023, 24'h0F0F0F, 24'hF0F0F0, 1, 24'h0F0F0F, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_write)
            begin
                if (!last_write)
                    drain_block();
                write_reg(plan[k].idx, plan[k].data);
                last_write = 1'b1;
            end
            else
            begin
                if (last_write)
                begin
                    wr_en <= 1'b0;
                    settings_applied++;
                end
                last_write = 1'b0;
                send_pixel(plan[k].px, plan[k].known, plan[k].emit, plan[k].res);
            end
        end
        directed_sent = pixels_sent;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            new_settings(ph == 0);
            steady = (ph == 2);
            // Hold the output for a long stretch so the pipeline fills and stalls the input
            if (ph == 4)
                hold_off = 400;
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                if (ph == 6 && n == PHASE_PIXELS / 2)
                begin
                    pixel_bus.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (composed_q.size() != 0);
                end
                send_pixel(random_pixel(), 1'b0, 1'b0, '0);
            end
        end
        steady = 1'b0;
        drain_block();

        $display("Sent %0d pixels (%0d from the directed table) under %0d register settings.",
                 pixels_sent, directed_sent, settings_applied);
        $display("Checked %0d composed pixels.", composed_checked);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
